[hdl/ttd_pkg.sv]
package ttd_pkg;

  // Default task capacity of each phase.
  localparam int MAX_TASKS_DEF = 64;

  // Fixed field widths.
  localparam int IDX_W  = 6;
  localparam int TOT_W  = 7;
  localparam int KIND_W = 2;

  // The first-free search looks at one slice of this many task bits per cycle.
  localparam int CHUNK_W = 16;
  localparam int PE_W    = $clog2(CHUNK_W);

  // Configuration port geometry.
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // Action codes.
  localparam logic ACT_ASK    = 1'b0;
  localparam logic ACT_SUBMIT = 1'b1;

  // Submitted task kinds.
  localparam logic [KIND_W-1:0] KIND_MAP    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REDUCE = 2'd1;

  // Granted task kinds.
  localparam logic [KIND_W-1:0] GK_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] GK_MAP    = 2'd1;
  localparam logic [KIND_W-1:0] GK_REDUCE = 2'd2;

  // Register select, taken from address bit 2.
  localparam logic REG_MAP_TOTAL    = 1'b0;
  localparam logic REG_REDUCE_TOTAL = 1'b1;

  typedef struct packed {
    logic              action;
    logic [KIND_W-1:0] task_kind;
    logic [IDX_W-1:0]  task_index;
  } in_item_t;

  typedef struct packed {
    logic              granted;
    logic [KIND_W-1:0] grant_kind;
    logic [IDX_W-1:0]  grant_index;
    logic              job_finished;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic submit;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic empty;
    logic out_free;
  } dp_stat_t;

endpackage

[hdl/ttd_stream_if.sv]
interface ttd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/two_phase_task_dispatcher.sv]
// Channel   Dir  Handshake         Payload
// in_ch     in   valid/ready       action, task_kind, task_index
// out_ch    out  valid/ready       granted, grant_kind, grant_index, job_finished
// cfg       in   psel/penable/pwrite, pready high   map_task_total @0, reduce_task_total @4
//
// A request is captured, then the first-free search walks one 16-task slice per step
// until a free task is found or the mask is empty, and then the result is posted.
// A submit runs through capture, state update, then the finished check and result.
// One transaction is worked at a time; the next is accepted while a result waits.
// Reset is synchronous, active low, and clears all task state and both totals.
// A stalled output register holds the final step until the result slot frees up.
module two_phase_task_dispatcher #(
  parameter int MAX_TASKS = ttd_pkg::MAX_TASKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ttd_stream_if.sink                 in_ch,
  ttd_stream_if.source               out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ttd_pkg::ADDR_W-1:0] paddr,
  input  logic [ttd_pkg::DATA_W-1:0] pwdata,
  output logic [ttd_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import ttd_pkg::*;

  logic [TOT_W-1:0] map_use;
  logic [TOT_W-1:0] red_use;
  dp_cmd_t          cmd;
  dp_stat_t         stat;
  in_item_t         in_item;
  out_item_t        out_item;
  logic             in_ready;
  logic             out_valid;

  assign pready   = 1'b1;
  assign in_item  = in_ch.payload;

  ttd_cfg #(
    .MAX_TASKS (MAX_TASKS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .map_use (map_use),
    .red_use (red_use)
  );

  ttd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_item.action),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ttd_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .map_use   (map_use),
    .red_use   (red_use),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

endmodule

[hdl/ttd_cfg.sv]
module ttd_cfg #(
  parameter int MAX_TASKS = ttd_pkg::MAX_TASKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttd_pkg::ADDR_W-1:0]  paddr,
  input  logic [ttd_pkg::DATA_W-1:0]  pwdata,
  output logic [ttd_pkg::DATA_W-1:0]  prdata,
  output logic [ttd_pkg::TOT_W-1:0]   map_use,
  output logic [ttd_pkg::TOT_W-1:0]   red_use
);
  import ttd_pkg::*;

  localparam logic [TOT_W-1:0] CAP = TOT_W'(MAX_TASKS);

  logic [TOT_W-1:0] map_total_r;
  logic [TOT_W-1:0] red_total_r;
  logic             wr_en;

  // A write completes in the access phase; pready is tied high.
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_total_r <= '0;
      red_total_r <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_MAP_TOTAL:    map_total_r <= pwdata[TOT_W-1:0];
        REG_REDUCE_TOTAL: red_total_r <= pwdata[TOT_W-1:0];
        default:          map_total_r <= map_total_r;
      endcase
    end
  end

  // Read back the stored register values.
  always_comb begin
    case (paddr[2])
      REG_MAP_TOTAL:    prdata = DATA_W'(map_total_r);
      REG_REDUCE_TOTAL: prdata = DATA_W'(red_total_r);
      default:          prdata = '0;
    endcase
  end

  // Totals above the capacity count as the full capacity.
  assign map_use = (map_total_r > CAP) ? CAP : map_total_r;
  assign red_use = (red_total_r > CAP) ? CAP : red_total_r;

endmodule

[hdl/ttd_ctrl.sv]
module ttd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_ready,
  input  ttd_pkg::dp_stat_t stat,
  output ttd_pkg::dp_cmd_t  cmd
);
  import ttd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SUBMIT,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_action == ACT_SUBMIT) ? S_SUBMIT : S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.step = 1'b1;
        if (stat.hit || stat.empty) begin
          state_nxt = S_DONE;
        end
      end
      S_SUBMIT: begin
        cmd.submit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        // Hold here until the output register can take the result.
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/ttd_dp.sv]
module ttd_dp #(
  parameter int MAX_TASKS = ttd_pkg::MAX_TASKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ttd_pkg::dp_cmd_t          cmd,
  output ttd_pkg::dp_stat_t         stat,
  input  ttd_pkg::in_item_t         in_item,
  input  logic [ttd_pkg::TOT_W-1:0] map_use,
  input  logic [ttd_pkg::TOT_W-1:0] red_use,
  input  logic                      out_ready,
  output logic                      out_valid,
  output ttd_pkg::out_item_t        out_item
);
  import ttd_pkg::*;

  localparam int NCHUNK = (MAX_TASKS + CHUNK_W - 1) / CHUNK_W;
  localparam int SRCH_W = NCHUNK * CHUNK_W;

  // Task state per phase.
  logic [MAX_TASKS-1:0] map_asg_r;
  logic [MAX_TASKS-1:0] map_cmp_r;
  logic [MAX_TASKS-1:0] red_asg_r;
  logic [MAX_TASKS-1:0] red_cmp_r;
  logic [TOT_W-1:0]     map_cnt_r;
  logic [TOT_W-1:0]     red_cnt_r;
  logic                 fin_r;

  // Current transaction and search state.
  in_item_t             item_r;
  logic                 phase_red_r;
  logic [SRCH_W-1:0]    srch_r;
  logic [TOT_W-1:0]     base_r;
  logic                 found_r;
  logic [IDX_W-1:0]     gidx_r;

  // Output register.
  logic                 out_valid_r;
  out_item_t            out_r;

  logic [MAX_TASKS-1:0] map_lim;
  logic [MAX_TASKS-1:0] red_lim;
  logic [MAX_TASKS-1:0] map_free;
  logic [MAX_TASKS-1:0] red_free;
  logic [MAX_TASKS-1:0] idx_hot;
  logic [MAX_TASKS-1:0] grant_hot;
  logic [MAX_TASKS-1:0] map_new;
  logic [MAX_TASKS-1:0] red_new;
  logic                 sel_red;
  logic [CHUNK_W-1:0]   chunk;
  logic [PE_W-1:0]      pe;
  logic                 grant_ok;
  logic                 fin_nxt;
  out_item_t            out_nxt;

  // Per-task limits, free masks and index decodes.
  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      map_lim[i]   = TOT_W'(i) < map_use;
      red_lim[i]   = TOT_W'(i) < red_use;
      idx_hot[i]   = item_r.task_index == IDX_W'(i);
      grant_hot[i] = gidx_r == IDX_W'(i);
    end
  end

  assign map_free = ~(map_asg_r | map_cmp_r) & map_lim;
  assign red_free = ~(red_asg_r | red_cmp_r) & red_lim;
  assign map_new  = idx_hot & map_lim & ~map_cmp_r;
  assign red_new  = idx_hot & red_lim & ~red_cmp_r;

  // The map phase is searched until its done count reaches the total.
  assign sel_red = !(map_cnt_r < map_use);

  // Lowest set bit of the current search slice.
  assign chunk = srch_r[CHUNK_W-1:0];
  always_comb begin
    pe = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (chunk[i]) begin
        pe = PE_W'(i);
      end
    end
  end

  assign stat.hit      = |chunk;
  assign stat.empty    = ~|srch_r;
  assign stat.out_free = !out_valid_r || out_ready;

  // Result assembly; the finished check runs after every submit.
  assign grant_ok = (item_r.action == ACT_ASK) && found_r;
  assign fin_nxt  = fin_r || ((item_r.action == ACT_SUBMIT) &&
                    (map_cnt_r >= map_use) && (red_cnt_r >= red_use));

  always_comb begin
    out_nxt              = '0;
    out_nxt.granted      = grant_ok;
    out_nxt.grant_kind   = GK_NONE;
    out_nxt.job_finished = fin_nxt;
    if (grant_ok) begin
      out_nxt.grant_kind  = phase_red_r ? GK_REDUCE : GK_MAP;
      out_nxt.grant_index = gidx_r;
    end
  end

  // Capture the transaction and walk the free mask one slice per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.load) begin
      item_r      <= in_item;
      phase_red_r <= sel_red;
      srch_r      <= sel_red ? SRCH_W'(red_free) : SRCH_W'(map_free);
      base_r      <= '0;
      found_r     <= 1'b0;
    end else if (cmd.step) begin
      if (|chunk) begin
        found_r <= 1'b1;
        gidx_r  <= IDX_W'(base_r + TOT_W'(pe));
      end else begin
        srch_r <= srch_r >> CHUNK_W;
        base_r <= base_r + TOT_W'(CHUNK_W);
      end
    end
  end

  // Task bits, done counts and the sticky finished flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_asg_r <= '0;
      map_cmp_r <= '0;
      red_asg_r <= '0;
      red_cmp_r <= '0;
      map_cnt_r <= '0;
      red_cnt_r <= '0;
      fin_r     <= 1'b0;
    end else begin
      if (cmd.submit) begin
        if (item_r.task_kind == KIND_MAP && |map_new) begin
          map_cmp_r <= map_cmp_r | map_new;
          map_asg_r <= map_asg_r & ~map_new;
          map_cnt_r <= map_cnt_r + TOT_W'(1);
        end
        if (item_r.task_kind == KIND_REDUCE && |red_new) begin
          red_cmp_r <= red_cmp_r | red_new;
          red_asg_r <= red_asg_r & ~red_new;
          red_cnt_r <= red_cnt_r + TOT_W'(1);
        end
      end
      if (cmd.finish) begin
        fin_r <= fin_nxt;
        if (grant_ok && phase_red_r) begin
          red_asg_r <= red_asg_r | grant_hot;
        end
        if (grant_ok && !phase_red_r) begin
          map_asg_r <= map_asg_r | grant_hot;
        end
      end
    end
  end

  // Output register; a new result loads only when the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
      out_r       <= out_nxt;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

[hdl/ttd_chk.sv]
module ttd_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ttd_pkg::out_item_t out_item
);
  import ttd_pkg::*;

  logic [1:0] pend_r;
  logic       fin_seen_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Count transactions accepted but not yet answered, and remember a finished report.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= '0;
      fin_seen_r <= 1'b0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
      if (out_acc && out_item.job_finished) begin
        fin_seen_r <= 1'b1;
      end
    end
  end

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Every result answers an accepted transaction.
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a pending transaction");

  // At most one transaction in work and one result waiting.
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many transactions outstanding");

  // Once reported, the finished flag stays set.
  a_fin_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fin_seen_r |-> out_item.job_finished)
    else $error("finished flag cleared");

endmodule

bind two_phase_task_dispatcher ttd_chk u_ttd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.payload)
);

[tb/tb_two_phase_task_dispatcher.sv]
module tb_two_phase_task_dispatcher;
  timeunit 1ns;
  timeprecision 1ps;

  import ttd_pkg::*;

  // Submitted kinds that the dispatcher must ignore.
  localparam logic [KIND_W-1:0] KIND_STRAY_LO = 2'd2;
  localparam logic [KIND_W-1:0] KIND_STRAY_HI = 2'd3;

  localparam int SETTLE_CYCLES   = 12;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 85;
  localparam int REPORT_LIMIT    = 10;
  localparam int PLAN_ROWS       = 27;
  localparam int EXPECT_DEPTH    = 1024;

  // One row of the directed plan: either a register write or one request/submit.
  typedef struct {
    logic             is_cfg;
    logic             reg_sel;
    logic [TOT_W-1:0] value;
    in_item_t         item;
    logic             typed;
    out_item_t        reply;
  } plan_row_t;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  ttd_stream_if #(.payload_t(in_item_t))  in_ch ();
  ttd_stream_if #(.payload_t(out_item_t)) out_ch ();

  two_phase_task_dispatcher dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the dispatcher state.
  logic [TOT_W-1:0] map_total_reg;
  logic [TOT_W-1:0] reduce_total_reg;
  logic [63:0]      map_assigned;
  logic [63:0]      map_completed;
  logic [63:0]      reduce_assigned;
  logic [63:0]      reduce_completed;
  logic [TOT_W-1:0] map_done;
  logic [TOT_W-1:0] reduce_done;
  logic             job_done;

  // Expected replies in order, kept in a ring with write and read counters.
  out_item_t expected_replies [EXPECT_DEPTH];
  int        exp_wr;
  int        exp_rd;
  plan_row_t directed_plan [PLAN_ROWS];
  int        mismatch_count;
  int        send_calm;
  int        recv_calm;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Totals above the task capacity saturate.
  function automatic int tasks_in_use(logic [TOT_W-1:0] reg_value);
    return (reg_value > 7'd64) ? 64 : int'(reg_value);
  endfunction

  function automatic int lowest_free(logic [63:0] busy, int total);
    for (int i = 0; i < total; i++) begin
      if (!busy[i]) return i;
    end
    return -1;
  endfunction

  // A submit counts only the first time a task inside the phase total completes.
  task automatic complete_task(inout logic [63:0] assigned, inout logic [63:0] completed,
                               inout logic [TOT_W-1:0] done, input int total,
                               input logic [IDX_W-1:0] idx);
    if (int'(idx) >= total || completed[idx]) return;
    completed[idx] = 1'b1;
    assigned[idx]  = 1'b0;
    done           = done + 7'd1;
  endtask

  task automatic predict_dispatch(input in_item_t it, output out_item_t reply);
    int mtot;
    int rtot;
    int slot;
    mtot  = tasks_in_use(map_total_reg);
    rtot  = tasks_in_use(reduce_total_reg);
    reply = '0;
    if (it.action == ACT_ASK) begin
      // Map tasks go out until the map phase is complete, then reduce tasks.
      if (int'(map_done) < mtot) begin
        slot = lowest_free(map_assigned | map_completed, mtot);
        if (slot >= 0) begin
          map_assigned[slot] = 1'b1;
          reply.granted      = 1'b1;
          reply.grant_kind   = GK_MAP;
          reply.grant_index  = slot[IDX_W-1:0];
        end
      end else begin
        slot = lowest_free(reduce_assigned | reduce_completed, rtot);
        if (slot >= 0) begin
          reduce_assigned[slot] = 1'b1;
          reply.granted         = 1'b1;
          reply.grant_kind      = GK_REDUCE;
          reply.grant_index     = slot[IDX_W-1:0];
        end
      end
    end else begin
      if (it.task_kind == KIND_MAP) begin
        complete_task(map_assigned, map_completed, map_done, mtot, it.task_index);
      end else if (it.task_kind == KIND_REDUCE) begin
        complete_task(reduce_assigned, reduce_completed, reduce_done, rtot, it.task_index);
      end
      // The finished check runs after every submit, even an ignored one.
      if (int'(map_done) >= mtot && int'(reduce_done) >= rtot) job_done = 1'b1;
    end
    reply.job_finished = job_done;
  endtask

  function automatic out_item_t grant_of(logic g, logic [KIND_W-1:0] gk,
                                         logic [IDX_W-1:0] gi, logic fin);
    out_item_t r;
    r.granted      = g;
    r.grant_kind   = gk;
    r.grant_index  = gi;
    r.job_finished = fin;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic reg_sel, logic [TOT_W-1:0] value);
    plan_row_t row;
    row         = '{default: '0};
    row.is_cfg  = 1'b1;
    row.reg_sel = reg_sel;
    row.value   = value;
    return row;
  endfunction

  function automatic plan_row_t item_row(logic act, logic [KIND_W-1:0] kind,
                                         logic [IDX_W-1:0] idx);
    plan_row_t row;
    row                 = '{default: '0};
    row.item.action     = act;
    row.item.task_kind  = kind;
    row.item.task_index = idx;
    return row;
  endfunction

  function automatic plan_row_t checked_row(logic act, logic [KIND_W-1:0] kind,
                                            logic [IDX_W-1:0] idx, out_item_t reply);
    plan_row_t row;
    row       = item_row(act, kind, idx);
    row.typed = 1'b1;
    row.reply = reply;
    return row;
  endfunction

  function automatic string reply_text(out_item_t r);
    return $sformatf("granted=%0d kind=%0d index=%0d finished=%0d",
                     r.granted, r.grant_kind, r.grant_index, r.job_finished);
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endtask

  // Each side either waits a random gap or runs through a calm stretch.
  function automatic int pick_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic int random_set_bit(logic [63:0] bits);
    int start;
    int j;
    start = $urandom_range(0, 63);
    for (int k = 0; k < 64; k++) begin
      j = (start + k) % 64;
      if (bits[j]) return j;
    end
    return 0;
  endfunction

  // Mostly asks and submits of tasks that are out with a worker, some noise.
  function automatic in_item_t random_request();
    in_item_t it;
    int       pick;
    it.action     = ACT_ASK;
    it.task_kind  = 2'($urandom_range(0, 3));
    it.task_index = 6'($urandom_range(0, 63));
    pick          = $urandom_range(0, 99);
    if (pick >= 45 && pick < 80) begin
      if (map_assigned != '0 && (reduce_assigned == '0 || $urandom_range(0, 1) == 0)) begin
        it.action     = ACT_SUBMIT;
        it.task_kind  = KIND_MAP;
        it.task_index = 6'(random_set_bit(map_assigned));
      end else if (reduce_assigned != '0) begin
        it.action     = ACT_SUBMIT;
        it.task_kind  = KIND_REDUCE;
        it.task_index = 6'(random_set_bit(reduce_assigned));
      end
    end else if (pick >= 80) begin
      it.action = ACT_SUBMIT;
    end
    return it;
  endfunction

  function automatic logic [TOT_W-1:0] phase_total(int phase);
    int top;
    top = (8 * phase + 8 > 63) ? 63 : 8 * phase + 8;
    case ($urandom_range(0, 7))
      0:       return 7'd0;
      1:       return 7'd64;
      2:       return 7'd127;
      3:       return 7'($urandom_range(65, 126));
      default: return 7'($urandom_range(0, top));
    endcase
  endfunction

  // Drive one transaction, then record its expected reply once accepted.
  task automatic send_item(input in_item_t it, input logic typed, input out_item_t reply);
    int        gap;
    out_item_t predicted;
    gap = pick_wait(send_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    predict_dispatch(it, predicted);
    expected_replies[exp_wr % EXPECT_DEPTH] = typed ? reply : predicted;
    exp_wr++;
  endtask

  // Stop sending and let every outstanding reply drain.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one total register, then read it back.
  task automatic program_total(input logic reg_sel, input logic [TOT_W-1:0] value);
    logic [DATA_W-1:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == REG_MAP_TOTAL) map_total_reg = value;
    else reduce_total_reg = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== DATA_W'(value)) begin
      note_mismatch($sformatf("register %0d readback: expected %0d, got %0d",
                              reg_sel, value, readback));
    end
  endtask

  // Stimulus: reset, the directed plan, then randomized phases.
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.payload    = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    map_total_reg    = '0;
    reduce_total_reg = '0;
    map_assigned     = '0;
    map_completed    = '0;
    reduce_assigned  = '0;
    reduce_completed = '0;
    map_done         = '0;
    reduce_done      = '0;
    job_done         = 1'b0;
    mismatch_count   = 0;
    send_calm        = 0;
    exp_wr           = 0;
    exp_rd           = 0;

    directed_plan = '{
      // Nothing configured: an ask finds no task.
      checked_row(ACT_ASK, KIND_MAP, 6'd0, grant_of(1'b0, GK_NONE, 6'd0, 1'b0)),
      cfg_row(REG_MAP_TOTAL, 7'd2),
      cfg_row(REG_REDUCE_TOTAL, 7'd1),
      checked_row(ACT_ASK, KIND_MAP, 6'd0, grant_of(1'b1, GK_MAP, 6'd0, 1'b0)),
      checked_row(ACT_ASK, KIND_MAP, 6'd0, grant_of(1'b1, GK_MAP, 6'd1, 1'b0)),
      checked_row(ACT_ASK, KIND_MAP, 6'd0, grant_of(1'b0, GK_NONE, 6'd0, 1'b0)),
      // Index beyond the total and both stray kinds are ignored.
      checked_row(ACT_SUBMIT, KIND_MAP, 6'd63, grant_of(1'b0, GK_NONE, 6'd0, 1'b0)),
      checked_row(ACT_SUBMIT, KIND_STRAY_LO, 6'd0, grant_of(1'b0, GK_NONE, 6'd0, 1'b0)),
      checked_row(ACT_SUBMIT, KIND_STRAY_HI, 6'd63, grant_of(1'b0, GK_NONE, 6'd0, 1'b0)),
      // A repeated submit is not counted twice.
      checked_row(ACT_SUBMIT, KIND_MAP, 6'd1, grant_of(1'b0, GK_NONE, 6'd0, 1'b0)),
      checked_row(ACT_SUBMIT, KIND_MAP, 6'd1, grant_of(1'b0, GK_NONE, 6'd0, 1'b0)),
      checked_row(ACT_ASK, KIND_MAP, 6'd0, grant_of(1'b0, GK_NONE, 6'd0, 1'b0)),
      checked_row(ACT_SUBMIT, KIND_MAP, 6'd0, grant_of(1'b0, GK_NONE, 6'd0, 1'b0)),
      // Map phase complete: reduce tasks go out.
      checked_row(ACT_ASK, KIND_MAP, 6'd0, grant_of(1'b1, GK_REDUCE, 6'd0, 1'b0)),
      checked_row(ACT_ASK, KIND_MAP, 6'd0, grant_of(1'b0, GK_NONE, 6'd0, 1'b0)),
      checked_row(ACT_SUBMIT, KIND_REDUCE, 6'd0, grant_of(1'b0, GK_NONE, 6'd0, 1'b1)),
      checked_row(ACT_ASK, KIND_MAP, 6'd0, grant_of(1'b0, GK_NONE, 6'd0, 1'b1)),
      // Saturating totals and the top index.
      cfg_row(REG_MAP_TOTAL, 7'd127),
      cfg_row(REG_REDUCE_TOTAL, 7'd64),
      item_row(ACT_ASK, KIND_MAP, 6'd0),
      item_row(ACT_SUBMIT, KIND_MAP, 6'd63),
      cfg_row(REG_MAP_TOTAL, 7'd0),
      cfg_row(REG_REDUCE_TOTAL, 7'd65),
      item_row(ACT_ASK, KIND_MAP, 6'd0),
      item_row(ACT_SUBMIT, KIND_REDUCE, 6'd63),
      item_row(ACT_SUBMIT, KIND_REDUCE, 6'd63),
      item_row(ACT_ASK, KIND_STRAY_HI, 6'd63)
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[r]) begin
      if (directed_plan[r].is_cfg) begin
        settle();
        program_total(directed_plan[r].reg_sel, directed_plan[r].value);
      end else begin
        send_item(directed_plan[r].item, directed_plan[r].typed, directed_plan[r].reply);
      end
    end

    // Random phases, each under its own pair of totals.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      if (phase == 0) begin
        program_total(REG_MAP_TOTAL, phase_total(phase));
        program_total(REG_REDUCE_TOTAL, 7'd0);
      end else if (phase == RANDOM_PHASES - 1) begin
        program_total(REG_MAP_TOTAL, 7'd64);
        program_total(REG_REDUCE_TOTAL, 7'd127);
      end else begin
        program_total(REG_MAP_TOTAL, phase_total(phase));
        program_total(REG_REDUCE_TOTAL, phase_total(phase));
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(random_request(), 1'b0, '0);
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Reply side: random stalls, each reply checked against the oldest expectation.
  initial begin
    int        gap;
    out_item_t got;
    out_item_t want;
    out_ch.ready = 1'b0;
    recv_calm    = 0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      gap = pick_wait(recv_calm);
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = out_ch.payload;
      if (exp_wr == exp_rd) begin
        note_mismatch($sformatf("unexpected reply: %s", reply_text(got)));
      end else begin
        want = expected_replies[exp_rd % EXPECT_DEPTH];
        exp_rd++;
        if (got.granted !== want.granted || got.grant_kind !== want.grant_kind ||
            got.grant_index !== want.grant_index || got.job_finished !== want.job_finished) begin
          note_mismatch($sformatf("reply mismatch: expected %s, got %s",
                                  reply_text(want), reply_text(got)));
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
